### rtl/assert_macros.svh
// Assertion macros used by the top level of the receive filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ipuf_pkg.sv
// Types, constants and helper functions of the IPv6/UDP receive filter.
`timescale 1ns / 1ps

package ipuf_pkg;

  localparam int DATA_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int PAYLOAD_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_OURS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UDP_ERR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_MAC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_IP_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_IP_LO  = 3'd6;

  localparam logic [47:0] RST_LOCAL_MAC   = 48'h0200_0000_0016;
  localparam logic [47:0] RST_PEER_MAC    = 48'h0200_0000_0021;
  localparam logic [63:0] RST_LOCAL_IP_HI = 64'hfd00_1499_2700_0000;
  localparam logic [63:0] RST_LOCAL_IP_LO = 64'h0000_0000_0000_0016;
  localparam logic [63:0] RST_PEER_IP_HI  = 64'hfd00_1499_2700_0000;
  localparam logic [63:0] RST_PEER_IP_LO  = 64'h0000_0000_0000_0021;

  localparam logic [15:0] ETHERTYPE_V6 = 16'h86dd;
  localparam logic [3:0]  IP_VERSION   = 4'd6;
  localparam logic [7:0]  NEXT_UDP     = 8'd17;
  localparam logic [7:0]  HOP_LIMIT    = 8'd64;
  localparam logic [15:0] PORT_SRC     = 16'd25933;
  localparam logic [15:0] PORT_DST     = 16'd25927;

  localparam int ETH_LEN   = 14;
  localparam int IP6_LEN   = 40;
  localparam int UDP_LEN   = 8;
  localparam int HDR_TOTAL = ETH_LEN + IP6_LEN + UDP_LEN;

  typedef struct packed {
    logic        enable;
    logic [47:0] local_mac;
    logic [47:0] peer_mac;
    logic [63:0] local_ip_hi;
    logic [63:0] local_ip_lo;
    logic [63:0] peer_ip_hi;
    logic [63:0] peer_ip_lo;
  } ipuf_cfg_t;

  // Everything the verdict needs once the last byte of a frame is in.
  typedef struct packed {
    logic        enable;
    logic        len_bad;
    logic        hdr_bad;
    logic        udp_bad;
    logic [15:0] sum;
    logic [15:0] pseudo;
    logic [15:0] udp_length;
  } ipuf_summary_t;

  // Ones' complement addition with a single end-around carry.
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

endpackage

### rtl/ipuf_in_if.sv
// Input channel of the receive filter: one frame byte and its last-byte marker.
`timescale 1ns / 1ps

interface ipuf_in_if;
  logic                        valid;
  logic                        ready;
  logic [ipuf_pkg::DATA_W-1:0] data_byte;
  logic                        last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/ipuf_out_if.sv
// Result channel of the receive filter: frame status and payload length.
`timescale 1ns / 1ps

interface ipuf_out_if;
  logic                           valid;
  logic                           ready;
  logic [ipuf_pkg::STATUS_W-1:0]  frame_status;
  logic [ipuf_pkg::PAYLOAD_W-1:0] payload_length;

  modport source(output valid, output frame_status, output payload_length, input ready);
  modport sink(input valid, input frame_status, input payload_length, output ready);
endinterface

### rtl/ipuf_parse.sv
// Per-byte header comparison, checksum accumulation and frame summary.
`timescale 1ns / 1ps

module ipuf_parse #(
  parameter int MAX_PAYLOAD_BYTES = 512,
  parameter int APP_HEADER_BYTES  = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [ipuf_pkg::DATA_W-1:0] data_byte,
  input  logic                        last_byte,
  input  ipuf_pkg::ipuf_cfg_t         cfg,
  output ipuf_pkg::ipuf_summary_t     summary
);

  localparam int FRAME_MAX = ipuf_pkg::HDR_TOTAL + APP_HEADER_BYTES + MAX_PAYLOAD_BYTES;
  localparam int CNT_W     = $clog2(FRAME_MAX + 2);
  localparam int UDP_MIN   = ipuf_pkg::UDP_LEN + APP_HEADER_BYTES;
  localparam int UDP_MAX   = UDP_MIN + MAX_PAYLOAD_BYTES;
  localparam int IP_UDP    = ipuf_pkg::ETH_LEN + ipuf_pkg::IP6_LEN;

  logic [CNT_W-1:0] cnt_r,      cnt_nxt;
  logic [15:0]      sum_r,      sum_nxt;
  logic             hdr_bad_r,  hdr_bad_nxt;
  logic [15:0]      udp_len_r,  udp_len_nxt;
  logic             port_bad_r, port_bad_nxt;
  logic [15:0]      csum_r,     csum_nxt;
  logic [15:0]      pseudo_r,   pseudo_nxt;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] mac_off;
  logic [CNT_W-1:0] ip_off;
  logic [2:0]       mac_sel;
  logic [2:0]       ip_sel;
  logic [63:0]      ip_word;
  logic             exp_hit;
  logic [7:0]       exp_val;
  logic             port_miss;

  assign pos     = cnt_r;
  assign mac_off = pos - CNT_W'(6);
  assign ip_off  = pos - CNT_W'(22);
  assign ip_sel  = ~ip_off[2:0];

  always_comb begin
    exp_hit = 1'b0;
    exp_val = '0;
    mac_sel = '0;
    ip_word = cfg.peer_ip_hi;
    unique case (ip_off[4:3])
      2'd0:    ip_word = cfg.peer_ip_hi;
      2'd1:    ip_word = cfg.peer_ip_lo;
      2'd2:    ip_word = cfg.local_ip_hi;
      default: ip_word = cfg.local_ip_lo;
    endcase
    if (pos < CNT_W'(6)) begin
      exp_hit = 1'b1;
      mac_sel = 3'd5 - pos[2:0];
      exp_val = cfg.local_mac[{mac_sel, 3'b000} +: 8];
    end else if (pos < CNT_W'(12)) begin
      exp_hit = 1'b1;
      mac_sel = 3'd5 - mac_off[2:0];
      exp_val = cfg.peer_mac[{mac_sel, 3'b000} +: 8];
    end else if (pos == CNT_W'(12)) begin
      exp_hit = 1'b1;
      exp_val = ipuf_pkg::ETHERTYPE_V6[15:8];
    end else if (pos == CNT_W'(13)) begin
      exp_hit = 1'b1;
      exp_val = ipuf_pkg::ETHERTYPE_V6[7:0];
    end else if (pos == CNT_W'(20)) begin
      exp_hit = 1'b1;
      exp_val = ipuf_pkg::NEXT_UDP;
    end else if (pos == CNT_W'(21)) begin
      exp_hit = 1'b1;
      exp_val = ipuf_pkg::HOP_LIMIT;
    end else if (pos >= CNT_W'(22) && pos < CNT_W'(IP_UDP)) begin
      exp_hit = 1'b1;
      exp_val = ip_word[{ip_sel, 3'b000} +: 8];
    end
  end

  always_comb begin
    port_miss = 1'b0;
    if (pos == CNT_W'(IP_UDP)) begin
      port_miss = data_byte != ipuf_pkg::PORT_SRC[15:8];
    end else if (pos == CNT_W'(IP_UDP + 1)) begin
      port_miss = data_byte != ipuf_pkg::PORT_SRC[7:0];
    end else if (pos == CNT_W'(IP_UDP + 2)) begin
      port_miss = data_byte != ipuf_pkg::PORT_DST[15:8];
    end else if (pos == CNT_W'(IP_UDP + 3)) begin
      port_miss = data_byte != ipuf_pkg::PORT_DST[7:0];
    end
  end

  always_comb begin
    hdr_bad_nxt  = hdr_bad_r | (exp_hit && data_byte != exp_val) |
                   (pos == CNT_W'(14) && data_byte[7:4] != ipuf_pkg::IP_VERSION);
    port_bad_nxt = port_bad_r | port_miss;
    udp_len_nxt  = udp_len_r;
    csum_nxt     = csum_r;
    pseudo_nxt   = pseudo_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    if (pos == CNT_W'(18)) begin
      udp_len_nxt = {data_byte, udp_len_r[7:0]};
    end
    if (pos == CNT_W'(19)) begin
      udp_len_nxt = {udp_len_r[15:8], data_byte};
      // The UDP length and next-header part of the pseudo-header is folded in once the length is known.
      pseudo_nxt  = ipuf_pkg::fold_add({udp_len_r[15:8], data_byte},
                                       16'(ipuf_pkg::NEXT_UDP));
    end
    if (pos == CNT_W'(60)) begin
      csum_nxt = {data_byte, csum_r[7:0]};
    end
    if (pos == CNT_W'(61)) begin
      csum_nxt = {csum_r[15:8], data_byte};
    end
    if (pos >= CNT_W'(22)) begin
      sum_nxt = ipuf_pkg::fold_add(sum_r, pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00});
    end
    if (cnt_r <= CNT_W'(FRAME_MAX)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    summary.enable     = cfg.enable;
    summary.len_bad    = cnt_nxt < CNT_W'(ipuf_pkg::HDR_TOTAL) ||
                         cnt_nxt > CNT_W'(FRAME_MAX);
    summary.hdr_bad    = hdr_bad_nxt;
    summary.udp_bad    = udp_len_nxt < 16'(UDP_MIN) || udp_len_nxt > 16'(UDP_MAX) ||
                         ({1'b0, udp_len_nxt} + 17'(IP_UDP)) != 17'(cnt_nxt) ||
                         port_bad_nxt || csum_nxt == 16'h0000;
    summary.sum        = sum_nxt;
    summary.pseudo     = pseudo_nxt;
    summary.udp_length = udp_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      hdr_bad_r  <= 1'b0;
      udp_len_r  <= '0;
      port_bad_r <= 1'b0;
      csum_r     <= '0;
      pseudo_r   <= '0;
    end else if (take) begin
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
      udp_len_r  <= udp_len_nxt;
      port_bad_r <= port_bad_nxt;
      csum_r     <= csum_nxt;
      pseudo_r   <= pseudo_nxt;
    end
  end

endmodule

### rtl/ipv6_udp_rx_frame_filter.sv
// Top level of the IPv6/UDP receive frame filter: configuration, verdict and result register.
`timescale 1ns / 1ps
// The block takes an Ethernet frame one word (byte) at a time on in_if, with last_byte
// set on the final byte, and gives one result word on out_if for each frame: a status
// and the payload length behind the UDP header and the fixed application header.
// Bytes that are not the last give no result.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write them only
// while no frame is in flight, which the block does not enforce. Indices beyond the register
// list are ignored. Each byte is handled by the header compare and checksum logic as it is
// taken, so one byte is taken per cycle while in_if.ready is high. After the last byte is
// taken, the frame summary is registered in a summary register, where the checksum is closed
// and the status chosen; the result then goes to the output register that drives out_if.
// If the receiver stalls, one result waits in the output register and one frame summary
// behind it; once both are full, in_if.ready drops for every byte until out_if.ready returns.
// Reset returns the registers to their defaults (filter disabled), clears the frame
// state and empties both result stages; the first byte after reset opens a new frame.

`include "assert_macros.svh"

module ipv6_udp_rx_frame_filter #(
  parameter int MAX_PAYLOAD_BYTES = 512,
  parameter int APP_HEADER_BYTES  = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ipuf_in_if.sink                         in_if,
  ipuf_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [ipuf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipuf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int UDP_MIN = ipuf_pkg::UDP_LEN + APP_HEADER_BYTES;

  ipuf_pkg::ipuf_cfg_t     cfg_r;
  ipuf_pkg::ipuf_summary_t summary;
  ipuf_pkg::ipuf_summary_t fin_r;
  logic                    fin_valid_r, fin_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ipuf_pkg::STATUS_W-1:0]  status_r,  status_nxt;
  logic [ipuf_pkg::PAYLOAD_W-1:0] payload_r, payload_nxt;

  logic        take;
  logic        take_last;
  logic        out_free;
  logic        fin_move;
  logic [15:0] csum;
  logic [15:0] payload_wide;

  assign out_free    = !out_valid_r || out_if.ready;
  assign fin_move    = fin_valid_r && out_free;
  assign in_if.ready = !fin_valid_r || out_free;
  assign take        = in_if.valid && in_if.ready;
  assign take_last   = take && in_if.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.local_mac   <= ipuf_pkg::RST_LOCAL_MAC;
      cfg_r.peer_mac    <= ipuf_pkg::RST_PEER_MAC;
      cfg_r.local_ip_hi <= ipuf_pkg::RST_LOCAL_IP_HI;
      cfg_r.local_ip_lo <= ipuf_pkg::RST_LOCAL_IP_LO;
      cfg_r.peer_ip_hi  <= ipuf_pkg::RST_PEER_IP_HI;
      cfg_r.peer_ip_lo  <= ipuf_pkg::RST_PEER_IP_LO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipuf_pkg::CFG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        ipuf_pkg::CFG_LOCAL_MAC:   cfg_r.local_mac   <= cfg_data[47:0];
        ipuf_pkg::CFG_PEER_MAC:    cfg_r.peer_mac    <= cfg_data[47:0];
        ipuf_pkg::CFG_LOCAL_IP_HI: cfg_r.local_ip_hi <= cfg_data;
        ipuf_pkg::CFG_LOCAL_IP_LO: cfg_r.local_ip_lo <= cfg_data;
        ipuf_pkg::CFG_PEER_IP_HI:  cfg_r.peer_ip_hi  <= cfg_data;
        ipuf_pkg::CFG_PEER_IP_LO:  cfg_r.peer_ip_lo  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ipuf_parse #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .APP_HEADER_BYTES (APP_HEADER_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .data_byte(in_if.data_byte),
    .last_byte(in_if.last_byte),
    .cfg      (cfg_r),
    .summary  (summary)
  );

  assign csum         = ipuf_pkg::fold_add(fin_r.sum, fin_r.pseudo);
  assign payload_wide = fin_r.udp_length - 16'(UDP_MIN);

  always_comb begin
    status_nxt  = ipuf_pkg::ST_OK;
    payload_nxt = '0;
    if (!fin_r.enable) begin
      status_nxt = ipuf_pkg::ST_MALFORMED;
    end else if (fin_r.len_bad) begin
      status_nxt = ipuf_pkg::ST_BAD_LEN;
    end else if (fin_r.hdr_bad) begin
      status_nxt = ipuf_pkg::ST_NOT_OURS;
    end else if (fin_r.udp_bad || csum != 16'hffff) begin
      status_nxt = ipuf_pkg::ST_UDP_ERR;
    end else if (payload_wide == 16'h0000) begin
      status_nxt = ipuf_pkg::ST_MALFORMED;
    end else begin
      payload_nxt = payload_wide[ipuf_pkg::PAYLOAD_W-1:0];
    end
  end

  always_comb begin
    fin_valid_nxt = fin_valid_r;
    if (take_last) begin
      fin_valid_nxt = 1'b1;
    end else if (fin_move) begin
      fin_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fin_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      fin_r <= summary;
    end
    if (fin_move) begin
      status_r  <= status_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.frame_status   = status_r;
  assign out_if.payload_length = payload_r;

  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !fin_valid_r,
                 "result stages not empty after reset")
  `ASSERT_CLK(a_last_held, take_last |=> fin_valid_r,
              "frame end taken without a frame summary")
  `ASSERT_CLK(a_ok_has_payload,
              out_valid_r && status_r == ipuf_pkg::ST_OK |-> payload_r != '0,
              "accepted frame reports an empty payload")
  `ASSERT_CLK(a_reject_no_payload,
              out_valid_r && status_r != ipuf_pkg::ST_OK |-> payload_r == '0,
              "rejected frame reports a payload length")

endmodule
